// ----- design/nmad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmad_pkg
// Shared types and constants for the 3x3 max neighbour difference block.
// ----------------------------------------------------------------------------
package nmad_pkg;

  localparam int PIX_W  = 12;  // three masked nibbles, one per channel
  localparam int ROW_W  = 12;
  localparam int COLC_W = 12;  // column counter, holds any width - 1
  localparam int QDEPTH = 4;
  localparam int QCNT_W = 3;

  localparam logic [7:0] CHAN_MASK = 8'hF0;
  localparam logic       OP_PIXEL  = 1'b0;
  localparam logic       OP_DRAIN  = 1'b1;
  localparam logic       REG_WIDTH  = 1'b0;
  localparam logic       REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } wcol_t;

  // one classified item on its way from the front to the back
  typedef struct packed {
    wcol_t              col_data;
    logic               first;     // column 0: refill the window
    logic               emit_mid;  // emits the pixel one column back
    logic               emit_end;  // also emits the row's last pixel
    logic               last;      // frame_last on the row-end result
    logic [COLC_W-1:0]  col;
    logic [ROW_W-1:0]   row;
  } qent_t;

endpackage

// ----- design/nmad_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmad_front
// Position tracking, line memory read-modify-write and item classification.
// ----------------------------------------------------------------------------
module nmad_front import nmad_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [11:0]       image_width,
  input  logic [12:0]       image_height,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [7:0]        in_chan0,
  input  logic [7:0]        in_chan1,
  input  logic [7:0]        in_chan2,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_push,
  output qent_t             q_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [13:0] MAXW = 14'(MAX_WIDTH);

  // each entry: {two rows back, one row back}
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  logic              clr_busy_r;
  logic [AW-1:0]     clr_cnt_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COLC_W-1:0] col_r, col_nxt;

  logic              s1_valid_r;
  logic              s1_drain_r;
  logic              s1_row1_r;
  pix_t              s1_pix_r;
  logic [AW-1:0]     s1_addr_r;
  logic              s1_first_r, s1_mid_r, s1_end_r, s1_last_r;
  logic [COLC_W-1:0] s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [2*PIX_W-1:0] rd_r;
  logic              byp_r;
  logic [2*PIX_W-1:0] byp_data_r;

  logic [13:0]       w14, weff14;
  logic [COLC_W-1:0] weff, c;
  logic              accept, drain, last_col, active;
  logic [ROW_W-1:0]  orow;
  logic [AW-1:0]     addr;
  logic [2*PIX_W-1:0] line_now;
  pix_t              mid2, top2, bot2;
  logic              wr_en;

  always_comb begin
    w14    = {2'b00, image_width};
    if (image_width == '0) begin
      weff14 = 14'd1;
    end else if (w14 > MAXW) begin
      weff14 = MAXW;
    end else begin
      weff14 = w14;
    end
    weff     = weff14[COLC_W-1:0];
    c        = (col_r >= weff) ? weff - 1'b1 : col_r;
    last_col = (c == weff - 1'b1);
    drain    = (in_opcode == OP_DRAIN);
    active   = drain || (row_r != '0);
    orow     = row_r - 1'b1;
    addr     = c[AW-1:0];
    accept   = in_valid && !in_stall;
    col_nxt  = last_col ? '0 : c + 1'b1;
    row_nxt  = last_col ? (drain ? '0 : row_r + 1'b1) : row_r;
  end

  assign in_stall = clr_busy_r ||
                    (({1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid_r}) >= (QCNT_W+1)'(QDEPTH));

  // second stage: line data arrives, write back and hand over
  always_comb begin
    line_now = byp_r ? byp_data_r : rd_r;
    mid2     = line_now[PIX_W-1:0];
    top2     = s1_row1_r ? mid2 : line_now[2*PIX_W-1:PIX_W];
    bot2     = s1_drain_r ? mid2 : s1_pix_r;
    wr_en    = s1_valid_r && !s1_drain_r;
    q_push   = s1_valid_r;
    q_data.col_data = '{top: top2, mid: mid2, bot: bot2};
    q_data.first    = s1_first_r;
    q_data.emit_mid = s1_mid_r;
    q_data.emit_end = s1_end_r;
    q_data.last     = s1_last_r;
    q_data.col      = s1_col_r;
    q_data.row      = s1_row_r;
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      line_mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      line_mem[s1_addr_r] <= {mid2, bot2};
    end
    if (accept) begin
      rd_r       <= line_mem[addr];
      byp_r      <= wr_en && (s1_addr_r == addr);
      byp_data_r <= {mid2, bot2};
      s1_drain_r <= drain;
      s1_row1_r  <= (row_r == ROW_W'(1));
      s1_pix_r   <= {in_chan2[7:4] & CHAN_MASK[7:4], in_chan1[7:4] & CHAN_MASK[7:4],
                     in_chan0[7:4] & CHAN_MASK[7:4]};
      s1_addr_r  <= addr;
      s1_first_r <= (c == '0);
      s1_mid_r   <= (c != '0) && active;
      s1_end_r   <= last_col && active;
      s1_last_r  <= drain && (orow == image_height[ROW_W-1:0] - 1'b1);
      s1_col_r   <= c;
      s1_row_r   <= orow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MAX_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      s1_valid_r <= accept;
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

endmodule

// ----- design/nmad_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmad_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module nmad_fifo import nmad_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qent_t             push_data,
  input  logic              pop,
  output logic              pop_valid,
  output qent_t             pop_data,
  output logic [QCNT_W-1:0] count
);

  localparam int PW = $clog2(QDEPTH);

  qent_t             mem_r [QDEPTH];
  logic [PW-1:0]     wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rp_r];
  assign count     = cnt_r;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

endmodule

// ----- design/nmad_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmad_back
// 3x3 window, max neighbour difference and the result register.
// ----------------------------------------------------------------------------
module nmad_back import nmad_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  qent_t             q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_energy0,
  output logic [7:0]        out_energy1,
  output logic [7:0]        out_energy2,
  output logic [11:0]       out_row,
  output logic [10:0]       out_col,
  output logic              out_frame_last
);

  wcol_t             win_r [3];  // index 2 is the newest column
  logic              pend_mid_r, pend_end_r;
  logic [COLC_W-1:0] col_r;
  logic [ROW_W-1:0]  row_r;
  logic              last_r;

  logic              out_valid_r;
  logic [7:0]        e0_r, e1_r, e2_r;
  logic [11:0]       orow_r;
  logic [10:0]       ocol_r;
  logic              olast_r;

  wcol_t             sel [3];
  logic              any, out_free, move, done;
  logic [3:0]        best [3];
  logic [3:0]        ctr, v, d;
  logic [COLC_W-1:0] ecol;

  always_comb begin
    any      = pend_mid_r || pend_end_r;
    out_free = !out_valid_r || !out_stall;
    move     = any && out_free;
    done     = !any || (move && !(pend_mid_r && pend_end_r));
    q_pop    = q_valid && done;

    // row end: the window shifted once more with its right column replicated
    sel[0] = pend_mid_r ? win_r[0] : win_r[1];
    sel[1] = pend_mid_r ? win_r[1] : win_r[2];
    sel[2] = win_r[2];
    ecol   = pend_mid_r ? col_r - 1'b1 : col_r;

    for (int ch = 0; ch < 3; ch++) begin
      ctr      = sel[1].mid[4*ch +: 4];
      best[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        case (k % 3)
          0:       v = sel[k/3].top[4*ch +: 4];
          1:       v = sel[k/3].mid[4*ch +: 4];
          default: v = sel[k/3].bot[4*ch +: 4];
        endcase
        d = (v > ctr) ? v - ctr : ctr - v;
        if (d > best[ch]) begin
          best[ch] = d;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_data.first) begin
        win_r[0] <= q_data.col_data;
        win_r[1] <= q_data.col_data;
      end else begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
      end
      win_r[2] <= q_data.col_data;
      col_r    <= q_data.col;
      row_r    <= q_data.row;
      last_r   <= q_data.last;
    end
    if (move) begin
      e0_r    <= {best[0], 4'b0000};
      e1_r    <= {best[1], 4'b0000};
      e2_r    <= {best[2], 4'b0000};
      orow_r  <= row_r;
      ocol_r  <= ecol[10:0];
      olast_r <= !pend_mid_r && last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_mid_r  <= 1'b0;
      pend_end_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        pend_mid_r <= q_data.emit_mid;
        pend_end_r <= q_data.emit_end;
      end else if (move) begin
        if (pend_mid_r) begin
          pend_mid_r <= 1'b0;
        end else begin
          pend_end_r <= 1'b0;
        end
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_energy0    = e0_r;
  assign out_energy1    = e1_r;
  assign out_energy2    = e2_r;
  assign out_row        = orow_r;
  assign out_col        = ocol_r;
  assign out_frame_last = olast_r;

endmodule

// ----- design/neighbour_max_absdiff_energy.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour_max_absdiff_energy
// Streaming 3x3 maximum absolute neighbour difference on masked colour pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction per clock while in_stall is
// low. Each channel keeps its upper nibble; every result gives, per channel,
// the largest absolute difference to the eight neighbours (borders replicated),
// tagged with row and column, one row and one column behind the input. The last
// item of a row yields two results, which leave one after the other; otherwise,
// while out_stall is low, the block sustains one transaction per clock, since
// the line memory in the front takes one read and one write each cycle, with a
// bypass when neighbouring items hit the same entry. After the frame, image_width
// drain items flush the last row. After reset the MAX_WIDTH line memory entries
// are cleared while in_stall is high; configuration writes are taken throughout
// and should only happen while the block is idle.
// ----------------------------------------------------------------------------
module neighbour_max_absdiff_energy import nmad_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_chan0,
  input  logic [7:0]  in_chan1,
  input  logic [7:0]  in_chan2,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_energy0,
  output logic [7:0]  out_energy1,
  output logic [7:0]  out_energy2,
  output logic [11:0] out_row,
  output logic [10:0] out_col,
  output logic        out_frame_last
);

  logic [11:0]       width_r;
  logic [12:0]       height_r;

  logic              q_push, q_pop, q_valid;
  qent_t             q_in, q_out;
  logic [QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[11:0];
        REG_HEIGHT: height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // front: positions, line memory, classification
  nmad_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (width_r),
    .image_height (height_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_chan0     (in_chan0),
    .in_chan1     (in_chan1),
    .in_chan2     (in_chan2),
    .q_count      (q_count),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  // decoupling queue
  nmad_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out),
    .count     (q_count)
  );

  // back: window and results
  nmad_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_energy0    (out_energy0),
    .out_energy1    (out_energy1),
    .out_energy2    (out_energy2),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last)
  );

endmodule
